[rtl/gtr_pkg.sv]
// shared constants, codes and types of the graph traversal block
// no dependencies; compile first
package gtr_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned CntW     = NodeW + 1;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned CfgIdxW  = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegVertexCount   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegTraversalOrder = 1'd1;

  typedef enum logic [1:0] {
    OpWriteEdge    = 2'd0,
    OpClearVisited = 2'd1,
    OpTraverse     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StatNode  = 2'd0,
    StatRange = 2'd1,
    StatDone  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SEdgeWr,
    SPop,
    SRow,
    SScan
  } state_e;

  // access to the adjacency row store
  typedef struct packed {
    logic                re;
    logic                we;
    logic [NodeW-1:0]    addr;
    logic [MaxNodes-1:0] wdata;
  } adj_req_t;

endpackage

[rtl/gtr_adj_store.sv]
// adjacency row store: one row word per node, synchronous registered read
// rows never written read as zero through per-row valid bits; uses gtr_pkg
module gtr_adj_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gtr_pkg::adj_req_t            req_i,
  output logic [gtr_pkg::MaxNodes-1:0] rdata_o
);
  import gtr_pkg::*;

  logic [MaxNodes-1:0] mem [MaxNodes];
  logic [MaxNodes-1:0] row_valid_q;
  logic [MaxNodes-1:0] rdata_q;
  logic                rvalid_q;

  // row memory write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  // valid bits cleared at reset, set on the first write of a row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (req_i.we) begin
        row_valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= row_valid_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

[rtl/graph_traversal_bfs_dfs.sv]
// top level of the graph traversal block: control, visited marks, pending store
// depends on gtr_pkg and gtr_adj_store

// Writing an edge bit reads the row on acceptance, then writes it back and
// registers its done word in SEdgeWr, with busy high; clearing the visited
// marks and an out-of-range source leave busy low and give their word on the
// cycle after acceptance. A traversal passes each popped node through the
// pending-store read (SPop) and the adjacency row read (SRow), then scans the
// row in SScan at least once, pushing its unvisited neighbors one per scan step,
// and ends with a pop that finds the pending store empty. Words leave on
// result_strobe_o for exactly one cycle and cannot be held off; each emitted
// node is held back one step so that a traversal's final word carries last. Busy
// stays high through an edge write or traversal until its last word is issued.
module graph_traversal_bfs_dfs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation_i,
  input  logic [gtr_pkg::NodeW-1:0]    row_node_i,
  input  logic [gtr_pkg::NodeW-1:0]    col_node_i,
  input  logic                         edge_present_i,
  input  logic [gtr_pkg::NodeW-1:0]    source_node_i,
  input  logic                         cfg_we_i,
  input  logic [gtr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gtr_pkg::CfgDataW-1:0] cfg_wdata_i,
  output logic                         result_strobe_o,
  output logic [gtr_pkg::NodeW-1:0]    node_id_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);
  import gtr_pkg::*;

  state_e              state_q, state_d;
  logic [CfgDataW-1:0] vcount_q;
  logic                order_q;
  logic [MaxNodes-1:0] visited_q, visited_d;
  logic [CntW-1:0]     head_q, head_d;
  logic [CntW-1:0]     tail_q, tail_d;
  logic [MaxNodes-1:0] cand_q, cand_d;
  logic                first_q, first_d;
  logic [NodeW-1:0]    hold_q, hold_d;
  logic [NodeW-1:0]    col_q, col_d;
  logic [NodeW-1:0]    row_q, row_d;
  logic                bit_q, bit_d;
  logic                out_strobe_q, out_strobe_d;
  logic [NodeW-1:0]    out_node_q, out_node_d;
  logic [1:0]          out_status_q, out_status_d;
  logic                out_last_q, out_last_d;

  logic [NodeW-1:0]    pend_mem [MaxNodes];
  logic                pend_we, pend_re;
  logic [NodeW-1:0]    pend_waddr, pend_wdata, pend_raddr;
  logic [NodeW-1:0]    pend_rdata_q;

  adj_req_t            adj_req;
  logic [MaxNodes-1:0] adj_rdata;

  logic                accept;
  logic [CntW-1:0]     ncount;
  logic [MaxNodes-1:0] inuse;
  logic                src_ok;
  logic                edge_ok;
  logic                pend_empty;
  logic [MaxNodes-1:0] cand_cur;
  logic [MaxNodes-1:0] pick_mask;
  logic [NodeW-1:0]    pick_idx;
  logic                pick_found;
  logic [MaxNodes-1:0] cand_rest;
  logic [MaxNodes-1:0] row_new;
  logic [CntW-1:0]     tail_dec;

  gtr_adj_store u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (adj_req),
    .rdata_o (adj_rdata)
  );

  assign accept = start && (state_q == SIdle);
  assign busy   = (state_q != SIdle);

  // effective vertex count and in-use node mask
  always_comb begin
    if (vcount_q > CfgDataW'(MaxNodes)) begin
      ncount = CntW'(MaxNodes);
    end else begin
      ncount = CntW'(vcount_q);
    end
    for (int i = 0; i < MaxNodes; i++) begin
      inuse[i] = (CntW'(i) < ncount);
    end
  end

  assign src_ok   = ({1'b0, source_node_i} < ncount);
  assign edge_ok  = ({1'b0, row_node_i} < CntW'(MaxNodes)) &&
                    ({1'b0, col_node_i} < CntW'(MaxNodes));
  assign tail_dec = tail_q - CntW'(1);
  assign pend_empty = order_q ? (tail_q == '0) : (head_q == tail_q);

  // candidates of the current row, lowest unvisited neighbor first
  always_comb begin
    cand_cur   = first_q ? (adj_rdata & inuse & ~visited_q) : cand_q;
    pick_idx   = '0;
    pick_found = 1'b0;
    for (int i = MaxNodes - 1; i >= 0; i--) begin
      if (cand_cur[i]) begin
        pick_idx   = NodeW'(i);
        pick_found = 1'b1;
      end
    end
    pick_mask           = '0;
    pick_mask[pick_idx] = 1'b1;
    cand_rest           = cand_cur & ~pick_mask;
  end

  // edge bit merged into the row just read
  always_comb begin
    row_new         = adj_rdata;
    row_new[col_q]  = bit_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          case (operation_i)
            OpWriteEdge: if (edge_ok) state_d = SEdgeWr;
            OpTraverse:  if (src_ok) state_d = SPop;
            default:     state_d = SIdle;
          endcase
        end
      end
      SEdgeWr: state_d = SIdle;
      SPop:    state_d = pend_empty ? SIdle : SRow;
      SRow:    state_d = SScan;
      SScan: begin
        if (!pick_found || cand_rest == '0) state_d = SPop;
      end
      default: state_d = SIdle;
    endcase
  end

  // datapath, memory requests and result words
  always_comb begin
    visited_d    = visited_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cand_d       = cand_q;
    first_d      = first_q;
    hold_d       = hold_q;
    row_d        = row_q;
    col_d        = col_q;
    bit_d        = bit_q;
    out_strobe_d = 1'b0;
    out_node_d   = out_node_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    pend_we      = 1'b0;
    pend_waddr   = tail_q[NodeW-1:0];
    pend_wdata   = pick_idx;
    pend_re      = 1'b0;
    pend_raddr   = head_q[NodeW-1:0];
    adj_req      = '0;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          case (operation_i)
            OpWriteEdge: begin
              if (edge_ok) begin
                adj_req.re   = 1'b1;
                adj_req.addr = row_node_i;
                row_d        = row_node_i;
                col_d        = col_node_i;
                bit_d        = edge_present_i;
              end else begin
                out_strobe_d = 1'b1;
                out_node_d   = '0;
                out_status_d = StatDone;
                out_last_d   = 1'b1;
              end
            end
            OpClearVisited: begin
              visited_d    = '0;
              out_strobe_d = 1'b1;
              out_node_d   = '0;
              out_status_d = StatDone;
              out_last_d   = 1'b1;
            end
            OpTraverse: begin
              if (src_ok) begin
                pend_we                  = 1'b1;
                pend_waddr               = '0;
                pend_wdata               = source_node_i;
                head_d                   = '0;
                tail_d                   = CntW'(1);
                visited_d[source_node_i] = 1'b1;
                hold_d                   = source_node_i;
              end else begin
                out_strobe_d = 1'b1;
                out_node_d   = source_node_i;
                out_status_d = StatRange;
                out_last_d   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      SEdgeWr: begin
        adj_req.we    = 1'b1;
        adj_req.addr  = row_q;
        adj_req.wdata = row_new;
        out_strobe_d  = 1'b1;
        out_node_d    = '0;
        out_status_d  = StatDone;
        out_last_d    = 1'b1;
      end
      SPop: begin
        if (pend_empty) begin
          // traversal over: the held node is the final word
          out_strobe_d = 1'b1;
          out_node_d   = hold_q;
          out_status_d = StatNode;
          out_last_d   = 1'b1;
        end else begin
          pend_re = 1'b1;
          if (order_q) begin
            tail_d     = tail_dec;
            pend_raddr = tail_dec[NodeW-1:0];
          end else begin
            head_d     = head_q + CntW'(1);
            pend_raddr = head_q[NodeW-1:0];
          end
        end
      end
      SRow: begin
        adj_req.re   = 1'b1;
        adj_req.addr = pend_rdata_q;
        first_d      = 1'b1;
      end
      SScan: begin
        first_d = 1'b0;
        cand_d  = cand_rest;
        if (pick_found) begin
          // push the neighbor, issue the held word, hold the new one
          pend_we      = 1'b1;
          pend_waddr   = tail_q[NodeW-1:0];
          pend_wdata   = pick_idx;
          tail_d       = tail_q + CntW'(1);
          visited_d    = visited_q | pick_mask;
          out_strobe_d = 1'b1;
          out_node_d   = hold_q;
          out_status_d = StatNode;
          out_last_d   = 1'b0;
          hold_d       = pick_idx;
        end
      end
      default: ;
    endcase
  end

  // pending node store
  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    if (pend_re) begin
      pend_rdata_q <= pend_mem[pend_raddr];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= CfgDataW'(MaxNodes);
      order_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegVertexCount:    vcount_q <= cfg_wdata_i;
        RegTraversalOrder: order_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      visited_q    <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      first_q      <= 1'b0;
      out_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      visited_q    <= visited_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      first_q      <= first_d;
      out_strobe_q <= out_strobe_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cand_q       <= cand_d;
    hold_q       <= hold_d;
    row_q        <= row_d;
    col_q        <= col_d;
    bit_q        <= bit_d;
    out_node_q   <= out_node_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign result_strobe_o = out_strobe_q;
  assign node_id_o       = out_node_q;
  assign status_o        = out_status_q;
  assign last_o          = out_last_q;

endmodule

[test/tb_top.sv]
// self-checking testbench for graph_traversal_bfs_dfs: directed table, then random phases
// depends on gtr_pkg and the graph_traversal_bfs_dfs RTL; holds its own traversal predictor
`timescale 1ns / 100ps

module tb_top;
  import gtr_pkg::*;

  // operation code the block ignores
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned MaxPrinted = 40;

  typedef struct packed {
    logic [1:0]       op;
    logic [NodeW-1:0] row;
    logic [NodeW-1:0] col;
    logic             present;
    logic [NodeW-1:0] src;
  } stim_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [1:0]       status;
    logic             is_last;
  } word_t;

  typedef struct {
    bit                  is_reg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    stim_t               op_word;
    bit                  typed;
    word_t               typed_word;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          operation_i = '0;
  logic [NodeW-1:0]    row_node_i = '0;
  logic [NodeW-1:0]    col_node_i = '0;
  logic                edge_present_i = 1'b0;
  logic [NodeW-1:0]    source_node_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                result_strobe_o;
  logic [NodeW-1:0]    node_id_o;
  logic [1:0]          status_o;
  logic                last_o;

  graph_traversal_bfs_dfs dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .row_node_i     (row_node_i),
    .col_node_i     (col_node_i),
    .edge_present_i (edge_present_i),
    .source_node_i  (source_node_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_strobe_o(result_strobe_o),
    .node_id_o      (node_id_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  // predictor copy of the graph, marks and registers
  logic [MaxNodes-1:0] adj_rows [MaxNodes];
  logic [MaxNodes-1:0] visit_marks;
  logic [CfgDataW-1:0] vcount;
  logic                depth_first;

  word_t     step_words[$];
  word_t     walk_words[$];
  plan_row_t directed_plan[$];
  int        mismatch_count = 0;
  int unsigned cycle_count = 0;
  word_t     head_word;

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // append one expected word of the current item
  function automatic void put_step(input word_t w);
    step_words.insert(step_words.size(), w);
  endfunction

  // expected words of one item; updates the graph state
  function automatic void walk_graph(input stim_t it);
    logic [CfgDataW-1:0] nc;
    logic [MaxNodes-1:0] inuse;
    logic [MaxNodes-1:0] cand;
    logic [NodeW-1:0]    pend [MaxNodes];
    logic [NodeW-1:0]    cur;
    int head;
    int tail;
    step_words.delete();
    nc = (vcount > CfgDataW'(MaxNodes)) ? CfgDataW'(MaxNodes) : vcount;
    case (it.op)
      OpWriteEdge: begin
        adj_rows[it.row][it.col] = it.present;
        put_step('{node: '0, status: StatDone, is_last: 1'b1});
      end
      OpClearVisited: begin
        visit_marks = '0;
        put_step('{node: '0, status: StatDone, is_last: 1'b1});
      end
      OpTraverse: begin
        if ({1'b0, it.src} >= nc) begin
          put_step('{node: it.src, status: StatRange, is_last: 1'b1});
        end else begin
          inuse = (nc == CfgDataW'(MaxNodes)) ? '1 : ((64'd1 << nc) - 64'd1);
          head = 0;
          tail = 0;
          visit_marks[it.src] = 1'b1;
          pend[tail] = it.src;
          tail++;
          put_step('{node: it.src, status: StatNode, is_last: 1'b0});
          while (head < tail) begin
            // queue pops the oldest node, stack the newest
            if (depth_first) begin
              tail--;
              cur = pend[tail];
            end else begin
              cur = pend[head];
              head++;
            end
            cand = adj_rows[cur] & inuse & ~visit_marks;
            // neighbors in ascending order, marked as they are pushed
            for (int i = 0; i < nc && cand != '0; i++) begin
              if (cand[i]) begin
                cand[i] = 1'b0;
                visit_marks[i] = 1'b1;
                if (tail < MaxNodes && step_words.size() < MaxNodes) begin
                  pend[tail] = NodeW'(i);
                  tail++;
                  put_step('{node: NodeW'(i), status: StatNode, is_last: 1'b0});
                end
              end
            end
          end
          step_words[step_words.size()-1].is_last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o !== 1'b0) begin
      if (walk_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word node %0d status %0d last %0d",
                                node_id_o, status_o, last_o));
      end else begin
        head_word = walk_words.pop_front();
        if (result_strobe_o !== 1'b1 || node_id_o !== head_word.node ||
            status_o !== head_word.status || last_o !== head_word.is_last)
          flag_mismatch($sformatf("got node %0d status %0d last %0d, want %0d %0d %0d",
                                  node_id_o, status_o, last_o, head_word.node,
                                  head_word.status, head_word.is_last));
      end
    end
  end

  // drive one item, wait for acceptance, queue its expected words
  task automatic send_item(input stim_t it, input int idle_pct, input bit typed,
                           input word_t typed_w);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    operation_i    <= it.op;
    row_node_i     <= it.row;
    col_node_i     <= it.col;
    edge_present_i <= it.present;
    source_node_i  <= it.src;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    walk_graph(it);
    if (typed) walk_words.insert(walk_words.size(), typed_w);
    else foreach (step_words[k]) walk_words.insert(walk_words.size(), step_words[k]);
  endtask

  // stop sending and let every expected word come out
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (walk_words.size() != 0) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegVertexCount) vcount = val;
    else depth_first = val[0];
    @(posedge clk_i);
  endtask

  function automatic void add_op(input logic [1:0] op, input logic [NodeW-1:0] row, col,
                                 input logic present, input logic [NodeW-1:0] src,
                                 input bit typed = 1'b0, input logic [NodeW-1:0] exp_node = '0,
                                 input logic [1:0] exp_status = StatNode);
    plan_row_t r;
    r.is_reg     = 1'b0;
    r.reg_idx    = '0;
    r.reg_val    = '0;
    r.op_word    = '{op: op, row: row, col: col, present: present, src: src};
    r.typed      = typed;
    r.typed_word = '{node: exp_node, status: exp_status, is_last: 1'b1};
    directed_plan.insert(directed_plan.size(), r);
  endfunction

  function automatic void add_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    plan_row_t r;
    r.is_reg     = 1'b1;
    r.reg_idx    = idx;
    r.reg_val    = val;
    r.op_word    = '0;
    r.typed      = 1'b0;
    r.typed_word = '0;
    directed_plan.insert(directed_plan.size(), r);
  endfunction

  initial begin
    stim_t it;
    int span;
    int pick;
    int idle_pct;
    logic [CfgDataW-1:0] phase_vc;

    foreach (adj_rows[r]) adj_rows[r] = '0;
    visit_marks = '0;
    vcount      = CfgDataW'(MaxNodes);
    depth_first = 1'b0;

    // directed table: typed words where they follow at a glance
    add_op(OpTraverse, 0, 0, 0, 0, 1, 0, StatNode);        // lone source after reset
    add_op(OpWriteEdge, 0, 63, 1, 0, 1, 0, StatDone);
    add_op(OpWriteEdge, 63, 0, 1, 63, 1, 0, StatDone);
    add_op(OpWriteEdge, 0, 1, 1, 0, 1, 0, StatDone);
    add_op(OpWriteEdge, 1, 2, 1, 0, 1, 0, StatDone);
    add_op(OpClearVisited, 63, 63, 1, 63, 1, 0, StatDone);
    add_op(OpTraverse, 0, 0, 0, 0);                        // breadth-first walk
    add_op(OpUnused, 5, 5, 1, 5);                          // no word expected
    add_op(OpTraverse, 0, 0, 0, 0);                        // source already visited
    add_reg(RegTraversalOrder, 1);
    add_op(OpClearVisited, 0, 0, 0, 0, 1, 0, StatDone);
    add_op(OpTraverse, 0, 0, 0, 63);                       // depth-first walk
    add_op(OpWriteEdge, 0, 63, 0, 0, 1, 0, StatDone);      // remove an edge
    add_op(OpClearVisited, 0, 0, 0, 0, 1, 0, StatDone);
    add_op(OpTraverse, 0, 0, 0, 0);
    add_reg(RegVertexCount, 0);                            // every source out of range
    add_op(OpTraverse, 0, 0, 0, 0, 1, 0, StatRange);
    add_reg(RegVertexCount, 127);                          // clamps to the storage size
    add_op(OpClearVisited, 0, 0, 0, 0, 1, 0, StatDone);
    add_op(OpTraverse, 0, 0, 0, 63);
    add_reg(RegVertexCount, 2);
    add_op(OpTraverse, 0, 0, 0, 2, 1, 2, StatRange);
    add_op(OpTraverse, 0, 0, 0, 63, 1, 63, StatRange);
    add_op(OpWriteEdge, 5, 6, 1, 0, 1, 0, StatDone);       // stored beyond the vertex count
    add_op(OpClearVisited, 0, 0, 0, 0, 1, 0, StatDone);
    add_op(OpTraverse, 0, 0, 0, 0);                        // edge to node 2 masked
    add_reg(RegVertexCount, 1);
    add_op(OpTraverse, 0, 0, 0, 0);
    add_reg(RegVertexCount, 64);
    add_reg(RegTraversalOrder, 0);

    // reset
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (directed_plan[k]) begin
      if (directed_plan[k].is_reg) begin
        wait_idle();
        set_reg(directed_plan[k].reg_idx, directed_plan[k].reg_val);
      end else begin
        send_item(directed_plan[k].op_word, 0, directed_plan[k].typed,
                  directed_plan[k].typed_word);
      end
    end

    // random phases: no idling, heavy idling, no idling, light idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  phase_vc = 6; end
        1: begin idle_pct = 53; phase_vc = CfgDataW'($urandom_range(1, 127)); end
        2: begin idle_pct = 0;  phase_vc = 64; end
        default: begin idle_pct = 30; phase_vc = CfgDataW'($urandom_range(2, 20)); end
      endcase
      wait_idle();
      set_reg(RegVertexCount, phase_vc);
      set_reg(RegTraversalOrder, CfgDataW'($urandom_range(0, 1)));
      span = (phase_vc > MaxNodes) ? MaxNodes : phase_vc;
      for (int k = 0; k < 52; k++) begin
        // hold off once per phase until the block has emptied
        if (k == 26) wait_idle();
        it.row     = NodeW'($urandom_range(0, 63));
        it.col     = NodeW'($urandom_range(0, 63));
        it.src     = NodeW'($urandom_range(0, 63));
        it.present = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // edges mostly among the nodes in use so walks go deep
          it.op = OpWriteEdge;
          if ($urandom_range(0, 4) != 0) begin
            it.row = NodeW'($urandom_range(0, span - 1));
            it.col = NodeW'($urandom_range(0, span - 1));
          end
        end else if (pick < 67) begin
          it.op = OpClearVisited;
        end else if (pick < 95) begin
          it.op = OpTraverse;
          if ($urandom_range(0, 5) != 0) it.src = NodeW'($urandom_range(0, span - 1));
        end else begin
          it.op = OpUnused;
        end
        send_item(it, idle_pct, 1'b0, '0);
      end
    end

    // drain, then watch for stray words
    wait_idle();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
